FILE: hw/rtl/kts_pkg.sv
`timescale 1ns / 1ps

package kts_pkg;

    localparam int KEY_W         = 32;
    localparam int TAG_W         = 16;
    localparam int DATA_W        = KEY_W + TAG_W;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
    } kts_item_t;

    typedef struct packed {
        logic      ins;
        logic      pop;
        kts_item_t item;
    } kts_cmd_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } kts_state_t;

endpackage

FILE: hw/rtl/key_tag_sorter.sv
`timescale 1ns / 1ps
// Channel   Signals                  Contents
// s_axis    tvalid tready tdata      tdata: key[31:0], tag[47:32]
//           tlast                    last_in
// m_axis    tvalid tready tdata      tdata: sorted_key[31:0], sorted_tag[47:32]
//           tlast tuser              last_out, tuser: overflow
//
// Requests are loaded one per cycle; each one is inserted into the chain of cells in that cycle.
// After the request marked last, the n held pairs leave one per cycle from the head cell
// while the output is ready; a request that finds the chain full is not inserted but sets tuser.
// No request is taken while a set is being emitted; a stalled result holds in the head cell.
// Reset clears the fill count, the drop flag and the state; cell contents are not reset.

module key_tag_sorter #(
    parameter int MAX_ITEMS = kts_pkg::MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [kts_pkg::DATA_W-1:0] s_axis_tdata,  // key, tag
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [kts_pkg::DATA_W-1:0] m_axis_tdata,  // sorted_key, sorted_tag
    output logic                      m_axis_tlast,
    output logic                      m_axis_tuser    // overflow
);
    import kts_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    kts_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;

    logic             in_acc;
    logic             full;
    logic             pop;
    kts_cmd_t         cmd;
    kts_item_t        items [MAX_ITEMS];
    logic             gts   [MAX_ITEMS];
    logic             valids[MAX_ITEMS];

    assign full   = (count_reg == CNT_W'(MAX_ITEMS));
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign cmd.ins  = in_acc && !full;
    assign cmd.pop  = pop;
    assign cmd.item = kts_item_t'(s_axis_tdata);

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            assign valids[i] = (count_reg > CNT_W'(i));
            kts_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .valid     (valids[i]),
                .prev_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
                .prev_item ((i == 0) ? cmd.item : items[(i == 0) ? 0 : i - 1]),
                .next_item ((i == MAX_ITEMS - 1) ? items[i] :
                            items[(i == MAX_ITEMS - 1) ? i : i + 1]),
                .gt        (gts[i]),
                .item      (items[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pop && (count_reg == CNT_W'(1)))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_axis_tready = 1'b1;
            end
            ST_DRAIN:
            begin
                m_axis_tvalid = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign pop          = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = items[0];
    assign m_axis_tlast = (count_reg == CNT_W'(1));
    assign m_axis_tuser = dropped_reg;

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (in_acc)
        begin
            dropped_next = 1'b1;
        end
        if (pop)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> count_reg != '0)
        else $error("emitting from an empty chain");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && count_reg > CNT_W'(1)) |-> items[0].key <= items[1].key)
        else $error("head cells out of order");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && m_axis_tlast) |=> (s_axis_tready && count_reg == '0 && !dropped_reg))
        else $error("set not cleared after final result");
`endif

endmodule

FILE: hw/rtl/kts_cell.sv
`timescale 1ns / 1ps

module kts_cell (
    input  logic              clk,
    input  kts_pkg::kts_cmd_t cmd,
    input  logic              valid,
    input  logic              prev_gt,
    input  kts_pkg::kts_item_t prev_item,
    input  kts_pkg::kts_item_t next_item,
    output logic              gt,
    output kts_pkg::kts_item_t item
);
    import kts_pkg::*;

    kts_item_t item_reg;
    kts_item_t item_next;

    // An empty cell, or one holding a strictly greater key, makes room for the new request.
    assign gt = !valid || (item_reg.key > cmd.item.key);

    always_comb
    begin
        item_next = item_reg;
        if (cmd.ins && gt)
        begin
            item_next = prev_gt ? prev_item : cmd.item;
        end
        else if (cmd.pop)
        begin
            item_next = next_item;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

FILE: sim/tb_key_tag_sorter.sv
`timescale 1ns / 1ps

module tb_key_tag_sorter;
    import kts_pkg::*;

    typedef struct {
        kts_item_t item;
        logic      last;
        logic      hold;
    } request_t;

    typedef struct {
        kts_item_t item;
        logic      last;
        logic      overflow;
    } sorted_t;

    localparam int CAPACITY = MAX_ITEMS_DEF;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    request_t  pending_requests[$];
    sorted_t   expected_sorted[$];
    kts_item_t sort_store[CAPACITY];
    int        held_count = 0;
    logic      held_dropped = 1'b0;
    request_t  in_flight;
    sorted_t   oldest_sorted;
    int        sent_count = 0;
    int        seen_count = 0;
    int        error_count = 0;

    key_tag_sorter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Each request settles behind every held key that is less than or equal to its own,
    // so equal keys keep their arrival order.
    function automatic void absorb_request(request_t r);
        int      pos;
        sorted_t s;
        if (held_count >= CAPACITY)
        begin
            held_dropped = 1'b1;
        end
        else
        begin
            pos = held_count;
            while (pos > 0 && sort_store[pos-1].key > r.item.key)
            begin
                sort_store[pos] = sort_store[pos-1];
                pos--;
            end
            sort_store[pos] = r.item;
            held_count++;
        end
        if (r.last)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                s.item     = sort_store[i];
                s.last     = (i == held_count - 1);
                s.overflow = held_dropped;
                expected_sorted.push_back(s);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void add_request(logic [31:0] key, logic [15:0] tag, logic last,
                                        logic hold);
        request_t r;
        r.item.key = key;
        r.item.tag = tag;
        r.last     = last;
        r.hold     = hold;
        pending_requests.push_back(r);
    endfunction

    function automatic logic [31:0] random_key();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(16) - 8;
            4, 5, 6:    return v;
            7:
            begin
                case ($urandom_range(5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    3:       return 32'hffff_ffff;
                    4:       return 32'h8000_0001;
                    default: return 32'h7fff_fffe;
                endcase
            end
            default:    return {{16{v[15]}}, v[15:0]};
        endcase
    endfunction

    function automatic logic [15:0] random_tag();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_random_set(int size, logic hold);
        for (int i = 0; i < size; i++)
            add_request(random_key(), random_tag(), i == size - 1, hold && i == 0);
    endfunction

    function automatic int random_set_size();
        case ($urandom_range(9))
            8:       return $urandom_range(40, 13);
            9:       return $urandom_range(68, 60);
            default: return $urandom_range(12, 1);
        endcase
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_key_tag_sorter: errors");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_request(in_flight);
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() != 0
                    && !(pending_requests[0].hold && expected_sorted.size() != 0)
                    && ((sent_count >= 200 && sent_count < 270) || $urandom_range(99) >= 34))
                begin
                    in_flight = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= in_flight.item;
                    s_axis_tlast  <= in_flight.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sorted.size() == 0)
                begin
                    $display("%0t: result key %h tag %h arrived with nothing expected",
                             $time, m_axis_tdata[KEY_W-1:0], m_axis_tdata[DATA_W-1:KEY_W]);
                    error_count++;
                end
                else
                begin
                    oldest_sorted = expected_sorted.pop_front();
                    check_field("sorted_key", oldest_sorted.item.key,
                                m_axis_tdata[KEY_W-1:0]);
                    check_field("sorted_tag", 32'(oldest_sorted.item.tag),
                                32'(m_axis_tdata[DATA_W-1:KEY_W]));
                    check_field("last_out", 32'(oldest_sorted.last), 32'(m_axis_tlast));
                    check_field("overflow", 32'(oldest_sorted.overflow),
                                32'(m_axis_tuser));
                end
                seen_count++;
            end
            m_axis_tready <= (seen_count >= 250 && seen_count < 340)
                             || $urandom_range(99) >= 34;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        add_request(32'h8000_0000, 16'hffff, 1'b1, 1'b0);

        add_request(32'h7fff_ffff, 16'h0001, 1'b0, 1'b0);
        add_request(32'h8000_0000, 16'h0002, 1'b0, 1'b0);
        add_request(32'h0000_0000, 16'h0000, 1'b0, 1'b0);
        add_request(32'hffff_ffff, 16'h0003, 1'b0, 1'b0);
        add_request(32'h0000_0005, 16'h0004, 1'b0, 1'b0);
        add_request(32'h0000_0005, 16'h0005, 1'b0, 1'b0);
        add_request(32'hffff_ffff, 16'h0006, 1'b0, 1'b0);
        add_request(32'h7fff_ffff, 16'h0007, 1'b0, 1'b0);
        add_request(32'h8000_0000, 16'h0008, 1'b0, 1'b0);
        add_request(32'h0000_0001, 16'hffff, 1'b1, 1'b0);

        add_request(32'h0000_0007, 16'h0010, 1'b0, 1'b1);
        add_request(32'h0000_0007, 16'h0011, 1'b1, 1'b0);

        for (int i = 0; i < 5; i++)
            add_request(4 - i, 16'h0020 + 16'(i), i == 4, 1'b0);

        // A full set, then sets that lose their last item and two items to the full store.
        add_random_set(64, 1'b1);
        add_random_set(65, 1'b0);
        add_random_set(66, 1'b0);
        while (pending_requests.size() < 410)
            add_random_set(random_set_size(), $urandom_range(3) == 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (error_count == 0)
            $display("tb_key_tag_sorter: clean");
        else
            $display("tb_key_tag_sorter: errors");
        $finish;
    end

endmodule
